>>> design/wes_pkg.sv
package wes_pkg;

   localparam int MaxWordsDefault = 64;
   localparam int WordBitsDefault = 16;
   localparam int CodeWidth       = 16;
   localparam int SimWidth        = 10;
   localparam int DistWidth       = 7;
   localparam int Scale           = 1000;

   typedef enum logic [1:0] {
      OP_FIRST  = 2'd0,
      OP_SECOND = 2'd1,
      OP_FINISH = 2'd2,
      OP_NONE   = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROW,
      ST_DIV,
      ST_OUT
   } back_state_type;

endpackage

>>> design/wes_if.sv
interface wes_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  opcode;
   logic [15:0] word_code;
   modport source (output valid, output opcode, output word_code, input ready);
   modport sink (input valid, input opcode, input word_code, output ready);
endinterface

interface wes_rsp_if;
   logic       valid;
   logic       ready;
   logic [9:0] similarity;
   logic [6:0] distance;
   logic       overflow;
   modport source (output valid, output similarity, output distance, output overflow,
                   input ready);
   modport sink (input valid, input similarity, input distance, input overflow,
                 output ready);
endinterface

>>> design/word_edit_similarity_core.sv
// Channel   Dir  Payload
// req       in   opcode[1:0], word_code[15:0]
// rsp       out  similarity[9:0], distance[6:0], overflow
//
// An accepted beat waits in the queue until the back end pops it. A first-text
// word is stored, and a second-text word sweeps a cost row column by column
// if the first text is not empty. A finish divides, then holds until rsp.ready.
// Synchronous reset clears the counts and the flag; the first sweep after a clear
// rebuilds the cost columns from their indexes. A four-entry queue lets requests
// arrive while the back end is busy, and ignored opcodes never enter it.
module word_edit_similarity_core #(
   parameter int MaxWords = wes_pkg::MaxWordsDefault,
   parameter int WordBits = wes_pkg::WordBitsDefault
) (
   input logic       clock,
   input logic       reset,
   wes_req_if.sink   req,
   wes_rsp_if.source rsp
);
   import wes_pkg::*;

   logic                q_valid, q_pop;
   opcode_type          q_op;
   logic [WordBits-1:0] q_code;

   wes_front #(.WordBits(WordBits)) u_front (
      .clock, .reset, .req, .q_valid, .q_pop, .q_op, .q_code);

   wes_back #(.MaxWords(MaxWords), .WordBits(WordBits)) u_back (
      .clock, .reset, .q_valid, .q_pop, .q_op, .q_code, .rsp);
endmodule

>>> design/wes_front.sv
// Front end: decodes each request beat, drops the opcodes that do nothing and
// queues the rest for the back end in a small FIFO.
module wes_front #(
   parameter int WordBits = wes_pkg::WordBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   wes_req_if.sink               req,
   output logic                  q_valid,
   input  logic                  q_pop,
   output wes_pkg::opcode_type   q_op,
   output logic [WordBits-1:0]   q_code
);
   import wes_pkg::*;

   localparam int Depth = 4;

   opcode_type          op_mem [Depth];
   logic [WordBits-1:0] code_mem [Depth];
   logic [1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 3'(Depth));
   assign push      = req.valid && req.ready && (opcode_type'(req.opcode) != OP_NONE);
   assign q_valid   = (cnt_ff != 3'd0);
   assign q_op      = op_mem[rd_ff];
   assign q_code    = code_mem[rd_ff];

   // Pointer and fill count update.
   always_comb begin
      wr_in  = push ? wr_ff + 2'd1 : wr_ff;
      rd_in  = q_pop ? rd_ff + 2'd1 : rd_ff;
      cnt_in = cnt_ff + 3'(push) - 3'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         op_mem[wr_ff]   <= opcode_type'(req.opcode);
         code_mem[wr_ff] <= req.word_code[WordBits-1:0];
      end
   end
endmodule

>>> design/wes_back.sv
// Back end: stores the first text, sweeps one cost row per second-text word
// (when the first text is not empty) one column per cycle, and divides bit-serially on finish.
module wes_back #(
   parameter int MaxWords = wes_pkg::MaxWordsDefault,
   parameter int WordBits = wes_pkg::WordBitsDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  q_valid,
   output logic                  q_pop,
   input  wes_pkg::opcode_type   q_op,
   input  logic [WordBits-1:0]   q_code,
   wes_rsp_if.source             rsp
);
   import wes_pkg::*;

   localparam int LW = $clog2(MaxWords + 1);
   localparam int AW = $clog2(MaxWords);
   localparam int NW = LW + 10;

   back_state_type st_ff, st_in;
   logic [WordBits-1:0] words [MaxWords];
   logic [LW-1:0] row [MaxWords];
   logic [LW-1:0] flen_ff, slen_ff, j_ff, diag_ff, left_ff, tail_ff;
   logic [LW-1:0] row_q_ff;
   logic [WordBits-1:0] word_q_ff, code_ff;
   logic fresh_ff;
   logic ovf_ff;
   logic [NW-1:0] num_ff, quo_ff;
   logic [NW-1:0] rem_ff;
   logic [4:0] bit_ff;
   logic [LW-1:0] longest_ff, dist_ff;
   logic [SimWidth-1:0] sim_ff;
   logic [LW-1:0] up, cand, best, fin_dist, longest;
   logic [NW-1:0] rem_sh;
   logic [LW-1:0] wd_j;
   logic start_row;

   // Column j is stored at row[j-1]. On the first sweep after a clear the stored
   // columns are ignored and each column's own index is used in their place.
   assign up     = fresh_ff ? j_ff : row_q_ff;
   assign wd_j   = j_ff - LW'(1);
   assign cand   = diag_ff + ((word_q_ff == code_ff) ? LW'(0) : LW'(1));
   always_comb begin
      best = (up < left_ff) ? up + LW'(1) : left_ff + LW'(1);
      if (cand < best) best = cand;
   end
   assign longest  = (flen_ff > slen_ff) ? flen_ff : slen_ff;
   assign fin_dist = (tail_ff > longest) ? longest : tail_ff;
   assign rem_sh   = {rem_ff[NW-2:0], num_ff[NW-1]};

   // A second-text word needs a column sweep only when the first text is not empty and the second is not full.
   assign start_row = q_valid && q_op == OP_SECOND && slen_ff != LW'(MaxWords) &&
                      flen_ff != '0;

   // Next state.
   always_comb begin
      st_in = st_ff;
      case (st_ff)
         ST_IDLE: begin
            if (start_row) st_in = ST_ROW;
            else if (q_valid && q_op == OP_FINISH) st_in = ST_DIV;
         end
         ST_ROW:  if (j_ff >= flen_ff) st_in = ST_IDLE;
         ST_DIV:  if (bit_ff == 5'd0) st_in = ST_OUT;
         ST_OUT:  if (rsp.ready) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   // Outputs.
   always_comb begin
      q_pop          = (st_ff == ST_IDLE) && q_valid;
      rsp.valid      = (st_ff == ST_OUT);
      rsp.similarity = sim_ff;
      rsp.distance   = DistWidth'(dist_ff);
      rsp.overflow   = ovf_ff;
   end

   // Control registers. The tail register mirrors the cost of the last column.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= ST_IDLE;
         flen_ff <= '0;
         slen_ff <= '0;
         ovf_ff <= 1'b0;
         tail_ff <= '0;
      end else begin
         st_ff <= st_in;
         case (st_ff)
            ST_IDLE: if (q_valid) begin
               case (q_op)
                  OP_FIRST: if (slen_ff == '0) begin
                     if (flen_ff == LW'(MaxWords)) ovf_ff <= 1'b1;
                     else begin
                        flen_ff <= flen_ff + LW'(1);
                        tail_ff <= flen_ff + LW'(1);
                     end
                  end
                  OP_SECOND: begin
                     if (slen_ff == LW'(MaxWords)) ovf_ff <= 1'b1;
                     else begin
                        slen_ff <= slen_ff + LW'(1);
                        if (flen_ff == '0) tail_ff <= slen_ff + LW'(1);
                     end
                  end
                  default: ;
               endcase
            end
            ST_ROW: if (j_ff == flen_ff) tail_ff <= best;
            ST_OUT: if (rsp.ready) begin
               flen_ff <= '0;
               slen_ff <= '0;
               ovf_ff <= 1'b0;
               tail_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   // Datapath registers. Both stores are read one column ahead of the sweep.
   always_ff @(posedge clock) begin
      case (st_ff)
         ST_IDLE: if (q_valid) begin
            if (q_op == OP_FIRST && slen_ff == '0 && flen_ff != LW'(MaxWords))
               words[flen_ff[AW-1:0]] <= q_code;
            code_ff   <= q_code;
            fresh_ff  <= (slen_ff == '0);
            diag_ff   <= slen_ff;
            left_ff   <= slen_ff + LW'(1);
            j_ff      <= LW'(1);
            row_q_ff  <= row[0];
            word_q_ff <= words[0];
            longest_ff <= longest;
            dist_ff <= (longest == '0) ? '0 : fin_dist;
            num_ff  <= NW'(longest - fin_dist) * NW'(Scale);
            rem_ff  <= '0;
            quo_ff  <= '0;
            bit_ff  <= 5'(NW - 1);
         end
         ST_ROW: begin
            row[wd_j[AW-1:0]] <= best;
            row_q_ff  <= row[j_ff[AW-1:0]];
            word_q_ff <= words[j_ff[AW-1:0]];
            diag_ff <= up;
            left_ff <= best;
            j_ff <= j_ff + LW'(1);
         end
         ST_DIV: begin
            num_ff <= {num_ff[NW-2:0], 1'b0};
            if (rem_sh >= NW'(longest_ff)) begin
               rem_ff <= rem_sh - NW'(longest_ff);
               quo_ff <= {quo_ff[NW-2:0], 1'b1};
            end else begin
               rem_ff <= rem_sh;
               quo_ff <= {quo_ff[NW-2:0], 1'b0};
            end
            bit_ff <= bit_ff - 5'd1;
         end
         default: ;
      endcase
      if (st_ff == ST_DIV && bit_ff == 5'd0)
         sim_ff <= (longest_ff == '0) ? SimWidth'(Scale) :
                   SimWidth'({quo_ff[NW-2:0], (rem_sh >= NW'(longest_ff))});
   end
endmodule

>>> tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import wes_pkg::*;

   localparam int MaxWords = MaxWordsDefault;

   logic clock = 1'b0;
   logic reset = 1'b1;

   wes_req_if req ();
   wes_rsp_if rsp ();

   word_edit_similarity_core dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source)
   );

   always #10 clock = ~clock;

   // Result fields the design should produce, oldest first.
   typedef struct packed {
      logic [SimWidth-1:0]  similarity;
      logic [DistWidth-1:0] distance;
      logic                 overflow;
   } score_type;

   score_type score_queue[$];
   int     error_count = 0;
   bit     idle_enable = 1'b1;

   // Shadow copy of the edit-distance state.
   logic [CodeWidth-1:0] first_text[MaxWords];
   int                   first_len;
   int                   second_len;
   int                   cost_row[MaxWords+1];
   bit                   overflow_flag;

   function automatic void clear_texts();
      first_len     = 0;
      second_len    = 0;
      overflow_flag = 1'b0;
      for (int j = 0; j <= MaxWords; j++) cost_row[j] = j;
   endfunction

   // Advance the shadow state by one accepted beat and queue any score.
   function automatic void score_update(opcode_type op, logic [CodeWidth-1:0] code);
      int        diag, left, up, sub, best, longest, edit_dist;
      score_type s;
      case (op)
         OP_FIRST: begin
            if (second_len == 0) begin
               if (first_len >= MaxWords) begin
                  overflow_flag = 1'b1;
               end else begin
                  first_text[first_len] = code;
                  first_len++;
               end
            end
         end
         OP_SECOND: begin
            if (second_len >= MaxWords) begin
               overflow_flag = 1'b1;
            end else begin
               diag = cost_row[0];
               left = second_len + 1;
               cost_row[0] = left;
               for (int j = 1; j <= first_len; j++) begin
                  up   = cost_row[j];
                  sub  = diag + ((first_text[j-1] == code) ? 0 : 1);
                  best = (up + 1 < left + 1) ? up + 1 : left + 1;
                  if (sub < best) best = sub;
                  cost_row[j] = best;
                  diag = up;
                  left = best;
               end
               second_len++;
            end
         end
         OP_FINISH: begin
            longest = (first_len > second_len) ? first_len : second_len;
            edit_dist = 0;
            s.similarity = SimWidth'(Scale);
            if (longest != 0) begin
               edit_dist = cost_row[first_len];
               if (edit_dist > longest) edit_dist = longest;
               s.similarity = SimWidth'(((longest - edit_dist) * Scale) / longest);
            end
            s.distance = DistWidth'(edit_dist);
            s.overflow = overflow_flag;
            score_queue.insert(score_queue.size(), s);
            clear_texts();
         end
         default: ;
      endcase
   endfunction

   // Send one beat, with an optional random gap before it.
   task automatic send_word(opcode_type op, logic [CodeWidth-1:0] code);
      int gap;
      if (idle_enable && $urandom_range(3) == 0) begin
         gap = $urandom_range(15, 1);
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.opcode    <= op;
      req.word_code <= code;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      score_update(op, code);
   endtask

   task automatic release_bus();
      req.valid <= 1'b0;
   endtask

   // Draw a code from a small alphabet so that matches happen often.
   function automatic logic [CodeWidth-1:0] pick_code();
      if ($urandom_range(3) == 0) return CodeWidth'($urandom);
      return CodeWidth'($urandom_range(3));
   endfunction

   // Result side: random stalls and comparison against the oldest score.
   initial begin
      score_type s;
      rsp.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (idle_enable && $urandom_range(3) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         if (rsp.valid && rsp.ready) begin
            if (score_queue.size() == 0) begin
               $error("unexpected result beat");
               error_count++;
            end else begin
               s = score_queue.pop_front();
               if (rsp.similarity !== s.similarity) begin
                  $error("similarity: expected %0d, actual %0d", s.similarity,
                         rsp.similarity);
                  error_count++;
               end
               if (rsp.distance !== s.distance) begin
                  $error("distance: expected %0d, actual %0d", s.distance, rsp.distance);
                  error_count++;
               end
               if (rsp.overflow !== s.overflow) begin
                  $error("overflow: expected %0d, actual %0d", s.overflow, rsp.overflow);
                  error_count++;
               end
            end
         end
      end
   end

   // Directed: empty texts, extreme codes, ignored opcode, late first words.
   task automatic test_directed();
      send_word(OP_FINISH, '0);
      send_word(OP_FIRST, 16'h0000);
      send_word(OP_FIRST, 16'hFFFF);
      send_word(OP_NONE, 16'hFFFF);
      send_word(OP_SECOND, 16'hFFFF);
      send_word(OP_FIRST, 16'h1234);
      send_word(OP_SECOND, 16'h0000);
      send_word(OP_FINISH, 16'hFFFF);
      send_word(OP_SECOND, 16'hAAAA);
      send_word(OP_SECOND, 16'h5555);
      send_word(OP_FINISH, '0);
      send_word(OP_FIRST, 16'h5555);
      send_word(OP_FINISH, '0);
      send_word(OP_FIRST, 16'h0001);
      send_word(OP_SECOND, 16'h0001);
      send_word(OP_FINISH, '0);
   endtask

   // Both texts run past capacity so words are dropped and flagged, then both fill exactly to capacity.
   task automatic test_overflow();
      for (int i = 0; i < MaxWords + 2; i++) send_word(OP_FIRST, pick_code());
      for (int i = 0; i < MaxWords + 2; i++) send_word(OP_SECOND, pick_code());
      send_word(OP_FINISH, '0);
      for (int i = 0; i < MaxWords; i++) send_word(OP_FIRST, CodeWidth'(i));
      for (int i = 0; i < MaxWords; i++) send_word(OP_SECOND, CodeWidth'(i));
      send_word(OP_FINISH, '0);
   endtask

   // Random pairs of texts of mostly short length, with some noise beats.
   task automatic test_random(int beats);
      int sent, n1, n2;
      sent = 0;
      while (sent < beats) begin
         n1 = ($urandom_range(9) == 0) ? $urandom_range(MaxWords + 1) : $urandom_range(10);
         n2 = ($urandom_range(9) == 0) ? $urandom_range(MaxWords + 1) : $urandom_range(10);
         for (int i = 0; i < n1; i++) send_word(OP_FIRST, pick_code());
         for (int i = 0; i < n2; i++) begin
            if ($urandom_range(15) == 0) begin
               send_word(($urandom_range(1) == 0) ? OP_FIRST : OP_NONE, CodeWidth'($urandom));
               sent++;
            end
            send_word(OP_SECOND, pick_code());
         end
         send_word(OP_FINISH, CodeWidth'($urandom));
         sent += n1 + n2 + 1;
      end
   endtask

   initial begin
      req.valid     <= 1'b0;
      req.opcode    <= OP_NONE;
      req.word_code <= '0;
      clear_texts();
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_random(1150);
      idle_enable = 1'b0;
      test_random(300);
      release_bus();
      while (score_queue.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (error_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #20ms;
      $display("Verification failed");
      $finish;
   end

endmodule
